>>> src/tvie_pkg.sv
// ============================================================================
// tvie_pkg
// Opcodes, stream field widths and the control bundle shared by the
// tiny VM execute block.
// ============================================================================
package tvie_pkg;

    // Widths of the stream fields
    localparam int CMD_W  = 4;
    localparam int OPND_W = 4;
    localparam int IO_W   = 32;
    localparam int NI_W   = 8;

    // Bit positions in the result tuser
    localparam int UOUT_BIT  = 0;
    localparam int UHALT_BIT = 1;

    // Instruction opcodes
    typedef enum logic [CMD_W-1:0] {
        OP_EXIT    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_SAVE    = 4'd2,
        OP_ADD     = 4'd3,
        OP_SUB     = 4'd4,
        OP_GT      = 4'd5,
        OP_LT      = 4'd6,
        OP_EQ      = 4'd7,
        OP_IF      = 4'd8,
        OP_IN      = 4'd9,
        OP_OUT     = 4'd10,
        OP_GOTO    = 4'd11,
        OP_PERSIST = 4'd12,
        OP_RELOAD  = 4'd13,
        OP_CONST   = 4'd14,
        OP_MOVE    = 4'd15
    } op_t;

    // Side effects decided by the execute logic
    typedef struct packed {
        logic work_we;
        logic store_we;
        logic set_stop;
        logic emit;
    } exec_ctrl_t;

endpackage

>>> src/tiny_vm_instruction_execute.sv
// ============================================================================
// tiny_vm_instruction_execute
// Executes one decoded instruction per request for a 16-opcode machine.
// ============================================================================
// Usage:
//   The slave stream carries one decoded instruction per request. The master
//   stream returns one result per instruction: next instruction number,
//   emitted word and flags.
//   An instruction is registered together with its operand words, which are
//   read from the registered-read working RAM and backing store at
//   acceptance. It executes into the result register when that register is
//   free or being drained, so a result shows on the master side after passing
//   the operand register and then the result register. Throughput is one
//   instruction per cycle while the receiver does not stall: a single execute
//   stage sits between the operand register and the result register, and a
//   write by the executing instruction is forwarded to the one being accepted.
//   When the receiver stalls, the result register holds and the operand
//   register fills; then s_axis_tready drops until the result is taken.
//   Reset clears pc, the stop flag and per-entry valid bits of both RAMs,
//   so every word reads as zero at once; no clearing pass is needed.
//   After an exit instruction, later requests leave state untouched and
//   return the current pc with the halted flag set.
// ============================================================================
module tiny_vm_instruction_execute import tvie_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int PC_WIDTH   = 8,
    parameter int MEM_DEPTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, operand_a, operand_b, operand_c, input_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // next_instruction, out_value
    output logic [1:0]  m_axis_tuser    // out_valid, halted
);

    localparam int AW = $clog2(MEM_DEPTH);

    // Request fields
    op_t               s_cmd;
    logic [OPND_W-1:0] s_a;
    logic [OPND_W-1:0] s_b;
    logic [OPND_W-1:0] s_c;
    logic [IO_W-1:0]   s_iv;

    assign s_cmd = op_t'(s_axis_tdata[3:0]);
    assign s_a   = s_axis_tdata[7:4];
    assign s_b   = s_axis_tdata[11:8];
    assign s_c   = s_axis_tdata[15:12];
    assign s_iv  = s_axis_tdata[47:16];

    // Operand stage
    logic              in_vld_reg;
    op_t               cmd_reg;
    logic [OPND_W-1:0] a_reg;
    logic [OPND_W-1:0] b_reg;
    logic [OPND_W-1:0] c_reg;
    logic [IO_W-1:0]   iv_reg;
    logic              fwd0_reg;
    logic              fwd1_reg;
    logic              fwds_reg;
    logic              vld0_reg;
    logic              vld1_reg;
    logic              vlds_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;
    logic [DATA_WIDTH-1:0] fwds_data_reg;

    // Machine state
    logic [PC_WIDTH-1:0]  pc_reg;
    logic                 stop_reg;
    logic [MEM_DEPTH-1:0] work_vld_reg;
    logic [MEM_DEPTH-1:0] store_vld_reg;

    // Result register
    logic            out_vld_reg;
    logic [NI_W-1:0] ni_reg;
    logic            emit_reg;
    logic [IO_W-1:0] oval_reg;
    logic            halt_reg;

    logic s_accept;
    logic advance;

    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
    logic [AW-1:0] raddrs;

    logic [DATA_WIDTH-1:0] rd0;
    logic [DATA_WIDTH-1:0] rd1;
    logic [DATA_WIDTH-1:0] rds;
    logic [DATA_WIDTH-1:0] w0;
    logic [DATA_WIDTH-1:0] w1;
    logic [DATA_WIDTH-1:0] sw;

    exec_ctrl_t            ctrl;
    logic [AW-1:0]         work_waddr;
    logic [DATA_WIDTH-1:0] work_wdata;
    logic [AW-1:0]         store_waddr;
    logic [DATA_WIDTH-1:0] store_wdata;
    logic [PC_WIDTH-1:0]   pc_next;
    logic [IO_W-1:0]       out_word;
    logic                  work_we;
    logic                  store_we;
    logic                  stop_next;
    logic [15:0]           pc_wide;

    // Handshake: execute when the result register is free or being drained
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Pick read addresses: arithmetic reads b and c, the rest read a
    always_comb
    begin
        if (s_cmd inside {OP_ADD, OP_SUB, OP_GT, OP_LT, OP_EQ})
        begin
            raddr0 = AW'(s_b);
        end
        else
        begin
            raddr0 = AW'(s_a);
        end
        raddr1 = AW'(s_c);
        raddrs = AW'(s_a);
    end

    assign work_we  = advance && ctrl.work_we;
    assign store_we = advance && ctrl.store_we;

    // Working RAM, duplicated for two read ports
    tvie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_work0 (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (s_accept),
        .raddr (raddr0),
        .rdata (rd0)
    );

    tvie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_work1 (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (s_accept),
        .raddr (raddr1),
        .rdata (rd1)
    );

    // Backing store
    tvie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (s_accept),
        .raddr (raddrs),
        .rdata (rds)
    );

    // Operand words: forwarded write, else RAM word, else reset value
    assign w0 = fwd0_reg ? fwd_data_reg  : (vld0_reg ? rd0 : '0);
    assign w1 = fwd1_reg ? fwd_data_reg  : (vld1_reg ? rd1 : '0);
    assign sw = fwds_reg ? fwds_data_reg : (vlds_reg ? rds : '0);

    tvie_exec #(
        .DATA_WIDTH (DATA_WIDTH),
        .PC_WIDTH   (PC_WIDTH),
        .AW         (AW)
    ) u_exec (
        .cmd         (cmd_reg),
        .a           (a_reg),
        .b           (b_reg),
        .c           (c_reg),
        .iv          (iv_reg),
        .op0         (w0),
        .op1         (w1),
        .st          (sw),
        .pc          (pc_reg),
        .stopped     (stop_reg),
        .ctrl        (ctrl),
        .work_waddr  (work_waddr),
        .work_wdata  (work_wdata),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .pc_next     (pc_next),
        .out_word    (out_word)
    );

    assign stop_next = stop_reg || ctrl.set_stop;
    assign pc_wide   = 16'(pc_next);

    // Operand stage control: valid, forward and valid-bit flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            fwd0_reg   <= 1'b0;
            fwd1_reg   <= 1'b0;
            fwds_reg   <= 1'b0;
            vld0_reg   <= 1'b0;
            vld1_reg   <= 1'b0;
            vlds_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_vld_reg <= 1'b1;
                fwd0_reg   <= work_we && (work_waddr == raddr0);
                fwd1_reg   <= work_we && (work_waddr == raddr1);
                fwds_reg   <= store_we && (store_waddr == raddrs);
                vld0_reg   <= work_vld_reg[raddr0];
                vld1_reg   <= work_vld_reg[raddr1];
                vlds_reg   <= store_vld_reg[raddrs];
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
        end
    end

    // Operand stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg       <= s_cmd;
            a_reg         <= s_a;
            b_reg         <= s_b;
            c_reg         <= s_c;
            iv_reg        <= s_iv;
            fwd_data_reg  <= work_wdata;
            fwds_data_reg <= store_wdata;
        end
    end

    // Machine state update on execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            stop_reg      <= 1'b0;
            work_vld_reg  <= '0;
            store_vld_reg <= '0;
        end
        else if (advance)
        begin
            pc_reg   <= pc_next;
            stop_reg <= stop_next;
            if (work_we)
            begin
                work_vld_reg[work_waddr] <= 1'b1;
            end
            if (store_we)
            begin
                store_vld_reg[store_waddr] <= 1'b1;
            end
        end
    end

    // Result register: load on execute, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ni_reg   <= pc_wide[NI_W-1:0];
            emit_reg <= ctrl.emit;
            oval_reg <= out_word;
            halt_reg <= stop_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {oval_reg, ni_reg};
    assign m_axis_tuser  = {halt_reg, emit_reg};

endmodule

>>> src/tvie_ram.sv
// ============================================================================
// tvie_ram
// Generic single-write, single-read RAM with a registered read port.
// Read during write at the same address returns the old word.
// ============================================================================
module tvie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/tvie_exec.sv
// ============================================================================
// tvie_exec
// Combinational execute stage: decides writes, next pc and the emitted
// word for one instruction with its operands already fetched.
// ============================================================================
module tvie_exec import tvie_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int PC_WIDTH   = 8,
    parameter int AW         = 4
) (
    input  op_t                   cmd,
    input  logic [OPND_W-1:0]     a,
    input  logic [OPND_W-1:0]     b,
    input  logic [OPND_W-1:0]     c,
    input  logic [IO_W-1:0]       iv,
    input  logic [DATA_WIDTH-1:0] op0,      // word at b for arithmetic, else at a
    input  logic [DATA_WIDTH-1:0] op1,      // word at c
    input  logic [DATA_WIDTH-1:0] st,       // backing store word at a
    input  logic [PC_WIDTH-1:0]   pc,
    input  logic                  stopped,
    output exec_ctrl_t            ctrl,
    output logic [AW-1:0]         work_waddr,
    output logic [DATA_WIDTH-1:0] work_wdata,
    output logic [AW-1:0]         store_waddr,
    output logic [DATA_WIDTH-1:0] store_wdata,
    output logic [PC_WIDTH-1:0]   pc_next,
    output logic [IO_W-1:0]       out_word
);

    logic [63:0]           iv_ext;
    logic [63:0]           op0_ext;
    logic [PC_WIDTH-1:0]   pc_inc;
    logic [DATA_WIDTH-1:0] one_w;

    assign iv_ext  = {{(64-IO_W){iv[IO_W-1]}}, iv};
    assign op0_ext = 64'(op0);
    assign pc_inc  = PC_WIDTH'(pc + 1'b1);
    assign one_w   = DATA_WIDTH'(1);

    // Decode and execute
    always_comb
    begin
        ctrl        = '0;
        work_waddr  = AW'(a);
        work_wdata  = '0;
        store_waddr = AW'(b);
        store_wdata = op0;
        pc_next     = pc_inc;
        out_word    = '0;
        if (stopped)
        begin
            pc_next = pc;
        end
        else
        begin
            case (cmd)
                OP_EXIT:
                begin
                    ctrl.set_stop = 1'b1;
                end
                OP_LOAD:
                begin
                    ctrl.work_we = 1'b1;
                    work_waddr   = AW'(b);
                    work_wdata   = st;
                end
                OP_SAVE:
                begin
                    ctrl.store_we = 1'b1;
                end
                OP_ADD:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = op0 + op1;
                end
                OP_SUB:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = op0 - op1;
                end
                OP_GT:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = ($signed(op0) > $signed(op1)) ? one_w : '0;
                end
                OP_LT:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = ($signed(op0) < $signed(op1)) ? one_w : '0;
                end
                OP_EQ:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = (op0 == op1) ? one_w : '0;
                end
                OP_IF:
                begin
                    pc_next = (op0 != '0) ? PC_WIDTH'(b) : PC_WIDTH'(c);
                end
                OP_IN:
                begin
                    ctrl.work_we = 1'b1;
                    work_wdata   = iv_ext[DATA_WIDTH-1:0];
                end
                OP_OUT:
                begin
                    ctrl.emit = 1'b1;
                    out_word  = op0_ext[IO_W-1:0];
                end
                OP_GOTO:
                begin
                    pc_next = PC_WIDTH'(a);
                end
                OP_CONST:
                begin
                    ctrl.work_we = 1'b1;
                    work_waddr   = AW'(b);
                    work_wdata   = DATA_WIDTH'(a);
                end
                OP_MOVE:
                begin
                    ctrl.work_we = 1'b1;
                    work_waddr   = AW'(b);
                    work_wdata   = op0;
                end
                default:
                begin
                    // persist and reload only advance pc
                end
            endcase
        end
    end

endmodule

>>> src/tvie_checker.sv
// ============================================================================
// tvie_checker
// Port-level checks for the tiny VM execute block, bound to the top level.
// ============================================================================
module tvie_checker import tvie_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,   // next_instruction, out_value
    input logic [1:0]  m_axis_tuser    // out_valid, halted
);

    logic [1:0]      pend_reg;
    logic            halt_seen_reg;
    logic [NI_W-1:0] halt_pc_reg;
    logic            s_acc;
    logic            m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Track requests in flight and the pc frozen by a halt
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            halt_seen_reg <= 1'b0;
            halt_pc_reg   <= '0;
        end
        else
        begin
            pend_reg <= 2'(pend_reg + {1'b0, s_acc} - {1'b0, m_acc});
            if (m_acc && m_axis_tuser[UHALT_BIT])
            begin
                halt_seen_reg <= 1'b1;
                halt_pc_reg   <= m_axis_tdata[NI_W-1:0];
            end
        end
    end

    // No result without a pending request, and at most two in flight
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd3) && (!m_axis_tvalid || pend_reg != 2'd0))
        else $error("result without request or too many in flight");

    // No emitted word means a zero out_value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[UOUT_BIT] |-> m_axis_tdata[39:8] == 32'd0)
        else $error("out_value nonzero without out_valid");

    // A halted result never emits
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[UHALT_BIT] |-> !m_axis_tuser[UOUT_BIT])
        else $error("halted result emitted a word");

    // After a halt every result stays halted at the same pc
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && halt_seen_reg |->
            m_axis_tuser[UHALT_BIT] && (m_axis_tdata[NI_W-1:0] == halt_pc_reg))
        else $error("result after halt changed pc or cleared halted");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind tiny_vm_instruction_execute tvie_checker u_tvie_checker (.*);
